// File: sv/pst_pkg.sv
// Shared types and constants for the speed PID throttle/brake block.
// No dependencies; imported by every other module of the block.
`timescale 1ns / 1ps
`default_nettype none

package pst_pkg;

  // Field and datapath widths
  localparam int unsigned SpeedW  = 16;
  localparam int unsigned ErrW    = SpeedW + 1;  // target - measured, exact
  localparam int unsigned DiffW   = ErrW + 1;    // error - last error, exact
  localparam int unsigned GainW   = 16;
  localparam int unsigned CapW    = 23;
  localparam int unsigned SumW    = 32;          // integral, Q15.16
  localparam int unsigned DerivW  = 34;          // derivative, Q.8
  localparam int unsigned MulAW   = 35;
  localparam int unsigned MulBW   = GainW + 1;
  localparam int unsigned ProdW   = MulAW + MulBW;
  localparam int unsigned AccW    = 60;          // drive, Q.28
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = CapW;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CFG_KP       = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_KI       = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_KD       = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_CAP      = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_TSTEP    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_INV_TSTEP = 3'd5;

  // Reset values of the registers
  localparam logic [GainW-1:0] KP_RST        = 16'd2867;
  localparam logic [GainW-1:0] KI_RST        = 16'd614;
  localparam logic [GainW-1:0] KD_RST        = 16'd4;
  localparam logic [CapW-1:0]  CAP_RST       = 23'd43691;
  localparam logic [GainW-1:0] TSTEP_RST     = 16'd655;
  localparam logic [GainW-1:0] INV_TSTEP_RST = 16'd100;

  typedef struct packed {
    logic signed [SpeedW-1:0] target_speed;
    logic signed [SpeedW-1:0] measured_speed;
  } pst_in_t;

  typedef struct packed {
    logic signed [15:0] throttle;
    logic [14:0]        brake;
  } pst_out_t;

  typedef struct packed {
    logic [GainW-1:0] kp;
    logic [GainW-1:0] ki;
    logic [GainW-1:0] kd;
    logic [CapW-1:0]  integral_cap;
    logic [GainW-1:0] time_step;
    logic [GainW-1:0] inverse_time_step;
  } pst_cfg_t;

endpackage

`default_nettype wire

// File: sv/pid_speed_throttle_brake.sv
// Speed PID controller with integral anti-windup, throttle and brake outputs.
// Top level; depends on pst_pkg, pst_cfg and pst_mul.
`timescale 1ns / 1ps
`default_nettype none

// Each input beat carries a target and a measured speed (signed Q7.8) and
// yields one output beat with throttle (signed Q1.14, at most 1.0, saturated
// at -2.0) and brake (Q1.14, 0..1.0). Each item takes these steps in order:
// the accept cycle, five passes through the single shared 35x17
// multiplier (error*time_step, error change*inverse_time_step, then the kp,
// ki and kd terms), a step that adds the last product and a step that
// clamps and loads the output register, waiting while it holds a stalled result.
// in_stall_o stays high from the accept until the result enters the output
// register; a result waiting there does not block the next accept. The
// integral is clamped from above at integral_cap and saturated from below
// at the 32-bit signed minimum. The configuration port is always ready;
// write it only while the block is idle.

module pid_speed_throttle_brake
  import pst_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // input channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire pst_in_t            in_data_i,
  // output channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output pst_out_t                out_data_o,
  // configuration write channel
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgDatW-1:0] cfg_data_i
);

  // Sequencer codes: one state per use of the shared multiplier, plus idle, add and output states
  localparam logic [2:0] S_IDLE = 3'd0;  // wait for an input beat
  localparam logic [2:0] S_TS   = 3'd1;  // multiply error by time_step
  localparam logic [2:0] S_ITS  = 3'd2;  // update integral; error change * inv step
  localparam logic [2:0] S_KP   = 3'd3;  // hold derivative; kp * error
  localparam logic [2:0] S_KI   = 3'd4;  // start sum; ki * integral
  localparam logic [2:0] S_KD   = 3'd5;  // add integral term; kd * derivative
  localparam logic [2:0] S_ACC  = 3'd6;  // add derivative term
  localparam logic [2:0] S_OUT  = 3'd7;  // clamp and load the output register

  localparam logic signed [33:0] SumMin   = -34'sd2147483648;
  localparam logic signed [45:0] ThrMax   = 46'sd16384;
  localparam logic signed [45:0] ThrMin   = -46'sd32768;
  localparam logic signed [45:0] BrakeLim = -46'sd16384;

  pst_cfg_t cfg;

  logic [2:0] state_q, state_d;

  logic signed [ErrW-1:0]   err_q, err_d;
  logic signed [DiffW-1:0]  diff_q, diff_d;
  logic signed [ErrW-1:0]   last_err_q, last_err_d;
  logic signed [SumW-1:0]   esum_q, esum_d;
  logic signed [DerivW-1:0] deriv_q, deriv_d;
  logic signed [AccW-1:0]   acc_q, acc_d;

  logic                     out_valid_q, out_valid_d;
  pst_out_t                 out_q, out_d;

  logic signed [MulAW-1:0]  mul_a;
  logic signed [MulBW-1:0]  mul_b;
  logic signed [ProdW-1:0]  prod;

  logic in_take, out_take, out_free;

  // Integral update
  logic signed [33:0] inc;
  logic signed [33:0] sum_raw;
  logic signed [33:0] cap_ext;

  // Output shaping
  logic signed [45:0] d14;
  logic signed [45:0] d14_neg;
  logic signed [15:0] throttle;
  logic [14:0]        brake;

  // Configuration registers
  pst_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign cfg_ready_o = 1'b1;

  // Shared multiplier
  pst_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_TS: begin
        mul_a = MulAW'(err_q);
        mul_b = $signed({1'b0, cfg.time_step});
      end
      S_ITS: begin
        mul_a = MulAW'(diff_q);
        mul_b = $signed({1'b0, cfg.inverse_time_step});
      end
      S_KP: begin
        mul_a = MulAW'(err_q);
        mul_b = $signed({1'b0, cfg.kp});
      end
      S_KI: begin
        mul_a = MulAW'(esum_q);
        mul_b = $signed({1'b0, cfg.ki});
      end
      S_KD: begin
        mul_a = MulAW'(deriv_q);
        mul_b = $signed({1'b0, cfg.kd});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Integral: floor the Q.24 product down to Q.16, add, then clamp
  assign inc     = prod[41:8];
  assign sum_raw = 34'(esum_q) + inc;
  assign cap_ext = $signed({11'b0, cfg.integral_cap});

  // Drive in Q1.14, floored
  assign d14     = acc_q[AccW-1:14];
  assign d14_neg = -d14;

  always_comb begin
    if (d14 >= ThrMax) begin
      throttle = 16'sd16384;
    end else if (d14 < ThrMin) begin
      throttle = -16'sd32768;
    end else begin
      throttle = d14[15:0];
    end
  end

  always_comb begin
    brake = '0;
    if (d14[45] && err_q[ErrW-1]) begin
      if (d14 < BrakeLim) begin
        brake = 15'd16384;
      end else begin
        brake = d14_neg[14:0];
      end
    end
  end

  // Sequencer and datapath registers
  always_comb begin
    state_d     = state_q;
    err_d       = err_q;
    diff_d      = diff_q;
    last_err_d  = last_err_q;
    esum_d      = esum_q;
    deriv_d     = deriv_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_take) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_take) begin
          err_d      = ErrW'(in_data_i.target_speed) - ErrW'(in_data_i.measured_speed);
          diff_d     = DiffW'(err_d) - DiffW'(last_err_q);
          last_err_d = err_d;
          state_d    = S_TS;
        end
      end
      S_TS: begin
        state_d = S_ITS;
      end
      S_ITS: begin
        if (sum_raw >= cap_ext) begin
          esum_d = cap_ext[SumW-1:0];
        end else if (sum_raw < SumMin) begin
          esum_d = SumMin[SumW-1:0];
        end else begin
          esum_d = sum_raw[SumW-1:0];
        end
        state_d = S_KP;
      end
      S_KP: begin
        deriv_d = prod[DerivW-1:0];
        state_d = S_KI;
      end
      S_KI: begin
        acc_d   = {prod, 8'b0};
        state_d = S_KD;
      end
      S_KD: begin
        acc_d   = acc_q + AccW'(prod);
        state_d = S_ACC;
      end
      S_ACC: begin
        acc_d   = acc_q + {prod, 8'b0};
        state_d = S_OUT;
      end
      S_OUT: begin
        // hold the result until the output register frees
        if (out_free) begin
          out_d.throttle = throttle;
          out_d.brake    = brake;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      last_err_q  <= '0;
      esum_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_err_q  <= last_err_d;
      esum_q      <= esum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q   <= err_d;
    diff_q  <= diff_d;
    deriv_q <= deriv_d;
    acc_q   <= acc_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // An accepted beat always starts the multiply sequence
  a_accept_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> (state_q == S_TS))
    else $error("accepted beat did not start the sequence");

  // A new result only appears from the output state
  a_result_from_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> ($past(state_q) == S_OUT))
    else $error("result appeared outside the output state");

  // Braking implies a negative throttle
  a_brake_neg_thr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.brake != 15'd0)) |-> out_data_o.throttle[15])
    else $error("brake set with non-negative throttle");

  // The integral never rises above the largest possible cap
  a_esum_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    esum_q <= 32'sd8388607)
    else $error("integral above clamp range");

endmodule

`default_nettype wire

// File: sv/pst_cfg.sv
// Configuration register file of the speed PID block.
// Depends on pst_pkg for the register indexes, reset values and pst_cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module pst_cfg
  import pst_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               wr_en_i,
  input  wire logic [CfgIdxW-1:0] wr_index_i,
  input  wire logic [CfgDatW-1:0] wr_data_i,
  output pst_cfg_t                cfg_o
);

  pst_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        CFG_KP:        cfg_d.kp                = wr_data_i[GainW-1:0];
        CFG_KI:        cfg_d.ki                = wr_data_i[GainW-1:0];
        CFG_KD:        cfg_d.kd                = wr_data_i[GainW-1:0];
        CFG_CAP:       cfg_d.integral_cap      = wr_data_i[CapW-1:0];
        CFG_TSTEP:     cfg_d.time_step         = wr_data_i[GainW-1:0];
        CFG_INV_TSTEP: cfg_d.inverse_time_step = wr_data_i[GainW-1:0];
        default:       cfg_d = cfg_q;  // unmapped index: drop the write
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp                <= KP_RST;
      cfg_q.ki                <= KI_RST;
      cfg_q.kd                <= KD_RST;
      cfg_q.integral_cap      <= CAP_RST;
      cfg_q.time_step         <= TSTEP_RST;
      cfg_q.inverse_time_step <= INV_TSTEP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: sv/pst_mul.sv
// Shared signed multiplier with a registered product.
// Depends on pst_pkg for the operand and product widths.
`timescale 1ns / 1ps
`default_nettype none

module pst_mul
  import pst_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic signed [MulAW-1:0] a_i,
  input  wire logic signed [MulBW-1:0] b_i,
  output logic signed [ProdW-1:0]      p_o
);

  logic signed [ProdW-1:0] p_q, p_d;

  assign p_d = a_i * b_i;

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

`default_nettype wire
